// ----- hw/rtl/lbts_pkg.sv -----
// Package for the LRU buffer tag store: sizes, index types and the controller states.
// No dependencies.
package lbts_pkg;
    localparam int EntryCount  = 64;
    localparam int BucketCount = 64;
    localparam int IdxW        = $clog2(EntryCount);
    localparam int LnkW        = IdxW + 1;
    localparam int BktW        = (BucketCount > 1) ? $clog2(BucketCount) : 1;
    localparam int AddrW       = 32;
    localparam logic [LnkW-1:0] NoneIdx = LnkW'(EntryCount);

    localparam logic OpLookup   = 1'b0;
    localparam logic OpAllocate = 1'b1;

    typedef logic [IdxW-1:0] t_idx;
    typedef logic [LnkW-1:0] t_lnk;
    typedef logic [BktW-1:0] t_bkt;

    function automatic t_bkt bucket_of(logic [AddrW-1:0] a);
        return BktW'(a % BucketCount);
    endfunction

    function automatic logic lnk_ok(t_lnk e);
        return e < NoneIdx;
    endfunction

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_LREAD = 8'b00000010,
        S_LCHK  = 8'b00000100,
        S_PRO0  = 8'b00001000,
        S_PRO1  = 8'b00010000,
        S_UNC   = 8'b00100000,
        S_APP0  = 8'b01000000,
        S_APP1  = 8'b10000000
    } t_state;
endpackage

// ----- hw/rtl/lbts_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lbts_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    // write, then read registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- hw/rtl/lru_buffer_tag_store.sv -----
// LRU buffer tag store: 64 entries, one recency list and per-bucket hash chains.
// A request is taken when start is high and busy low; its single result appears for one
// cycle with o_done, and the receiver cannot stall it. A lookup reads the first link of its
// bucket and answers with a miss when that is empty; else it walks the bucket's chain. A
// miss answers when the chain ends; a hit first moves the entry to the most recent end,
// unless it is already most recent. An allocate takes the least recent entry, moves it to
// the most recent end, unchains its old address if valid, and adds it to the new bucket.
// The chain walk reads one entry per cycle from the tag RAM, and the list relinks are
// read-modify-writes on single-port-write RAMs. busy drops in the cycle the result is shown,
// so the next request may be taken then. After reset the block initialises all tables, one
// entry a cycle, holding busy high. Depends on lbts_pkg and lbts_ram.
module lru_buffer_tag_store (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_operation,
    input  logic [31:0] i_slice_address,
    output logic        o_done,
    output logic        o_hit,
    output logic [5:0]  o_entry_index,
    output logic        o_evicted_valid,
    output logic [31:0] o_evicted_address
);
    localparam int E  = lbts_pkg::EntryCount;
    localparam int IW = lbts_pkg::IdxW;
    localparam int LW = lbts_pkg::LnkW;
    localparam int BW = lbts_pkg::BktW;
    localparam int B  = lbts_pkg::BucketCount;
    localparam int AW = lbts_pkg::AddrW;
    localparam int CW = (E > B ? $clog2(E) : $clog2(B)) + 1;

    // control registers
    lbts_pkg::t_state r_st, n_st;
    logic [CW-1:0] r_clr, n_clr;
    logic r_op;
    logic [AW-1:0] r_addr;
    lbts_pkg::t_lnk r_head, n_head, r_tail, n_tail;
    lbts_pkg::t_lnk r_e, n_e;
    lbts_pkg::t_lnk r_cp, n_cp, r_cn, n_cn;
    logic r_oldv, n_oldv;
    logic [AW-1:0] r_oldaddr, n_oldaddr;
    lbts_pkg::t_idx r_guard, n_guard;
    logic n_done, n_hit, n_evv;
    logic [5:0] n_idx;
    logic [AW-1:0] n_eva;

    // memory ports; the tag RAM holds {valid, address}
    logic a_we; lbts_pkg::t_idx a_wa, a_ra; logic [AW:0] a_wd, a_rd;
    logic rp_we; lbts_pkg::t_idx rp_wa, rp_ra; lbts_pkg::t_lnk rp_wd, rp_rd;
    logic rn_we; lbts_pkg::t_idx rn_wa, rn_ra; lbts_pkg::t_lnk rn_wd, rn_rd;
    logic cn_we; lbts_pkg::t_idx cn_wa, cn_ra; lbts_pkg::t_lnk cn_wd, cn_rd;
    logic cp_we; lbts_pkg::t_idx cp_wa, cp_ra; lbts_pkg::t_lnk cp_wd, cp_rd;
    logic bf_we; lbts_pkg::t_bkt bf_wa, bf_ra; lbts_pkg::t_lnk bf_wd, bf_rd;
    logic bl_we; lbts_pkg::t_bkt bl_wa, bl_ra; lbts_pkg::t_lnk bl_wd, bl_rd;

    lbts_ram #(.Width(AW + 1), .Depth(E)) u_tag (.i_clk, .i_we(a_we), .i_waddr(a_wa),
        .i_wdata(a_wd), .i_raddr(a_ra), .o_rdata(a_rd));
    lbts_ram #(.Width(LW), .Depth(E)) u_rprev (.i_clk, .i_we(rp_we), .i_waddr(rp_wa),
        .i_wdata(rp_wd), .i_raddr(rp_ra), .o_rdata(rp_rd));
    lbts_ram #(.Width(LW), .Depth(E)) u_rnext (.i_clk, .i_we(rn_we), .i_waddr(rn_wa),
        .i_wdata(rn_wd), .i_raddr(rn_ra), .o_rdata(rn_rd));
    lbts_ram #(.Width(LW), .Depth(E)) u_cnext (.i_clk, .i_we(cn_we), .i_waddr(cn_wa),
        .i_wdata(cn_wd), .i_raddr(cn_ra), .o_rdata(cn_rd));
    lbts_ram #(.Width(LW), .Depth(E)) u_cprev (.i_clk, .i_we(cp_we), .i_waddr(cp_wa),
        .i_wdata(cp_wd), .i_raddr(cp_ra), .o_rdata(cp_rd));
    lbts_ram #(.Width(LW), .Depth(B)) u_bfirst (.i_clk, .i_we(bf_we), .i_waddr(bf_wa),
        .i_wdata(bf_wd), .i_raddr(bf_ra), .o_rdata(bf_rd));
    lbts_ram #(.Width(LW), .Depth(B)) u_blast (.i_clk, .i_we(bl_we), .i_waddr(bl_wa),
        .i_wdata(bl_wd), .i_raddr(bl_ra), .o_rdata(bl_rd));

    logic clearing;
    assign clearing = (r_clr < CW'(E > B ? E : B));
    assign busy = clearing || (r_st != lbts_pkg::S_IDLE);

    lbts_pkg::t_idx e_i;
    assign e_i = r_e[IW-1:0];

    lbts_pkg::t_bkt b_new, b_old;
    assign b_new = lbts_pkg::bucket_of(r_addr);
    assign b_old = lbts_pkg::bucket_of(r_oldaddr);

    // sequencer
    always_comb begin
        n_st = r_st; n_clr = r_clr;
        n_head = r_head; n_tail = r_tail; n_e = r_e;
        n_cp = r_cp; n_cn = r_cn; n_oldv = r_oldv; n_oldaddr = r_oldaddr;
        n_guard = r_guard;
        n_done = 1'b0; n_hit = 1'b0; n_idx = '0; n_evv = 1'b0; n_eva = '0;
        a_we = 1'b0; a_wa = e_i; a_wd = {1'b1, r_addr}; a_ra = e_i;
        rp_we = 1'b0; rp_wa = e_i; rp_wd = lbts_pkg::NoneIdx; rp_ra = e_i;
        rn_we = 1'b0; rn_wa = e_i; rn_wd = lbts_pkg::NoneIdx; rn_ra = e_i;
        cn_we = 1'b0; cn_wa = e_i; cn_wd = lbts_pkg::NoneIdx; cn_ra = e_i;
        cp_we = 1'b0; cp_wa = e_i; cp_wd = lbts_pkg::NoneIdx; cp_ra = e_i;
        bf_we = 1'b0; bf_wa = b_new; bf_wd = lbts_pkg::NoneIdx; bf_ra = b_new;
        bl_we = 1'b0; bl_wa = b_new; bl_wd = lbts_pkg::NoneIdx; bl_ra = b_new;
        if (clearing) begin
            // initialise one entry of every table per cycle
            n_clr = r_clr + 1'b1;
            a_we  = r_clr < CW'(E); a_wa = r_clr[IW-1:0]; a_wd = '0;
            rp_we = r_clr < CW'(E); rp_wa = r_clr[IW-1:0];
            rp_wd = (r_clr == '0) ? lbts_pkg::NoneIdx : LW'(r_clr - 1'b1);
            rn_we = r_clr < CW'(E); rn_wa = r_clr[IW-1:0];
            rn_wd = (r_clr == CW'(E - 1)) ? lbts_pkg::NoneIdx : LW'(r_clr + 1'b1);
            cn_we = r_clr < CW'(E); cn_wa = r_clr[IW-1:0];
            cp_we = r_clr < CW'(E); cp_wa = r_clr[IW-1:0];
            bf_we = r_clr < CW'(B); bf_wa = r_clr[BW-1:0];
            bl_we = r_clr < CW'(B); bl_wa = r_clr[BW-1:0];
        end else begin
            case (r_st)
                lbts_pkg::S_IDLE: begin
                    if (start) begin
                        n_guard = '0;
                        if (i_operation == lbts_pkg::OpLookup) begin
                            bf_ra = lbts_pkg::bucket_of(i_slice_address);
                            n_st = lbts_pkg::S_LREAD;
                        end else begin
                            // read everything held for the least recent entry
                            n_e = r_tail;
                            a_ra = r_tail[IW-1:0]; rp_ra = r_tail[IW-1:0];
                            rn_ra = r_tail[IW-1:0]; cp_ra = r_tail[IW-1:0];
                            cn_ra = r_tail[IW-1:0];
                            n_st = lbts_pkg::S_PRO0;
                        end
                    end
                end
                // first link of the bucket is now on bf_rd
                lbts_pkg::S_LREAD: begin
                    n_e = bf_rd;
                    a_ra = bf_rd[IW-1:0]; cn_ra = bf_rd[IW-1:0];
                    if (lbts_pkg::lnk_ok(bf_rd)) n_st = lbts_pkg::S_LCHK;
                    else begin n_done = 1'b1; n_st = lbts_pkg::S_IDLE; end
                end
                // compare one chain entry per cycle; recency links of it are read meanwhile
                lbts_pkg::S_LCHK: begin
                    if (a_rd[AW] && a_rd[AW-1:0] == r_addr) begin
                        n_st = lbts_pkg::S_PRO0;
                    end else if (lbts_pkg::lnk_ok(cn_rd) && r_guard != IW'(E - 1)) begin
                        n_e = cn_rd; n_guard = r_guard + 1'b1;
                        a_ra = cn_rd[IW-1:0]; cn_ra = cn_rd[IW-1:0];
                    end else begin
                        n_done = 1'b1; n_st = lbts_pkg::S_IDLE;
                    end
                end
                // recency relink: detach the entry from its neighbours
                lbts_pkg::S_PRO0: begin
                    n_oldv = a_rd[AW]; n_oldaddr = a_rd[AW-1:0];
                    n_cp = cp_rd; n_cn = cn_rd;
                    // own next link is no longer needed once captured
                    if (r_op == lbts_pkg::OpAllocate) begin
                        cn_we = 1'b1; cn_wa = e_i; cn_wd = lbts_pkg::NoneIdx;
                    end
                    if (r_head != r_e) begin
                        if (lbts_pkg::lnk_ok(rp_rd)) begin
                            rn_we = 1'b1; rn_wa = rp_rd[IW-1:0]; rn_wd = rn_rd;
                        end else begin
                            n_head = rn_rd;
                        end
                        if (lbts_pkg::lnk_ok(rn_rd)) begin
                            rp_we = 1'b1; rp_wa = rn_rd[IW-1:0]; rp_wd = rp_rd;
                        end else begin
                            n_tail = rp_rd;
                        end
                        n_st = lbts_pkg::S_PRO1;
                    end else if (r_op == lbts_pkg::OpLookup) begin
                        n_hit = 1'b1; n_idx = 6'(e_i); n_done = 1'b1;
                        n_st = lbts_pkg::S_IDLE;
                    end else if (a_rd[AW]) begin
                        n_st = lbts_pkg::S_UNC;
                    end else begin
                        n_st = lbts_pkg::S_APP0;
                    end
                end
                // recency relink: insert at the most recent end
                // (the previous link of the head is never used, so it is left as is)
                lbts_pkg::S_PRO1: begin
                    rn_we = 1'b1; rn_wa = e_i; rn_wd = r_head;
                    if (lbts_pkg::lnk_ok(r_head)) begin
                        rp_we = 1'b1; rp_wa = r_head[IW-1:0]; rp_wd = r_e;
                    end else begin
                        n_tail = r_e;
                    end
                    n_head = r_e;
                    if (r_op == lbts_pkg::OpLookup) begin
                        n_hit = 1'b1; n_idx = 6'(e_i); n_done = 1'b1;
                        n_st = lbts_pkg::S_IDLE;
                    end else if (r_oldv) begin
                        n_st = lbts_pkg::S_UNC;
                    end else begin
                        n_st = lbts_pkg::S_APP0;
                    end
                end
                // unchain the old address
                lbts_pkg::S_UNC: begin
                    if (lbts_pkg::lnk_ok(r_cp)) begin
                        cn_we = 1'b1; cn_wa = r_cp[IW-1:0]; cn_wd = r_cn;
                    end else begin
                        bf_we = 1'b1; bf_wa = b_old; bf_wd = r_cn;
                    end
                    if (lbts_pkg::lnk_ok(r_cn)) begin
                        cp_we = 1'b1; cp_wa = r_cn[IW-1:0]; cp_wd = r_cp;
                    end else begin
                        bl_we = 1'b1; bl_wa = b_old; bl_wd = r_cp;
                    end
                    n_st = lbts_pkg::S_APP0;
                end
                // append to new bucket: read its last entry after any unchain write
                lbts_pkg::S_APP0: begin
                    n_st = lbts_pkg::S_APP1;
                end
                lbts_pkg::S_APP1: begin
                    a_we = 1'b1;
                    cp_we = 1'b1; cp_wa = e_i; cp_wd = bl_rd;
                    if (lbts_pkg::lnk_ok(bl_rd)) begin
                        cn_we = 1'b1; cn_wa = bl_rd[IW-1:0]; cn_wd = r_e;
                    end else begin
                        bf_we = 1'b1; bf_wd = r_e;
                    end
                    bl_we = 1'b1; bl_wd = r_e;
                    n_done = 1'b1; n_idx = 6'(e_i);
                    n_evv = r_oldv;
                    n_eva = r_oldv ? r_oldaddr : '0;
                    n_st = lbts_pkg::S_IDLE;
                end
                default: n_st = lbts_pkg::S_IDLE;
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= lbts_pkg::S_IDLE; r_clr <= '0;
            r_head <= '0; r_tail <= LW'(E - 1); o_done <= 1'b0;
        end else begin
            r_st <= n_st; r_clr <= n_clr;
            r_head <= n_head; r_tail <= n_tail; o_done <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_e <= n_e; r_cp <= n_cp; r_cn <= n_cn;
        r_oldv <= n_oldv; r_oldaddr <= n_oldaddr; r_guard <= n_guard;
        o_hit <= n_hit; o_entry_index <= n_idx; o_evicted_valid <= n_evv;
        o_evicted_address <= n_eva;
        if (r_st == lbts_pkg::S_IDLE && start && !clearing) begin
            r_op <= i_operation; r_addr <= i_slice_address;
        end
    end
endmodule

// ----- tb/lbts_checker.sv -----
// Checker for the LRU buffer tag store: watches accepted requests and results, predicts them.
// Depends on lbts_pkg; instantiated beside the block by tb_lru_buffer_tag_store.
module lbts_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic        i_operation,
    input  logic [31:0] i_slice_address,
    input  logic        i_done,
    input  logic        i_hit,
    input  logic [5:0]  i_entry_index,
    input  logic        i_evicted_valid,
    input  logic [31:0] i_evicted_address,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_hit_count,
    output int          o_evict_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import lbts_pkg::*;

    typedef struct packed {
        logic        hit;
        logic [5:0]  idx;
        logic        ev_valid;
        logic [31:0] ev_addr;
    } t_tag_result;

    localparam int Nil = EntryCount;

    logic [31:0] tag_addr [EntryCount];
    logic        tag_valid [EntryCount];
    int          lru_prev [EntryCount];
    int          lru_next [EntryCount];
    int          lru_head, lru_tail;
    int          bkt_first [BucketCount];
    int          bkt_last [BucketCount];
    int          chn_prev [EntryCount];
    int          chn_next [EntryCount];
    t_tag_result expected_results [$];

    function automatic int bkt(logic [31:0] a);
        return int'(a % BucketCount);
    endfunction

    // Move an entry to the most recent end
    function automatic void make_recent(int e);
        int p, n;
        if (e == lru_head) return;
        p = lru_prev[e];
        n = lru_next[e];
        if (p != Nil) lru_next[p] = n; else lru_head = n;
        if (n != Nil) lru_prev[n] = p; else lru_tail = p;
        lru_prev[e] = Nil;
        lru_next[e] = lru_head;
        if (lru_head != Nil) lru_prev[lru_head] = e; else lru_tail = e;
        lru_head = e;
    endfunction

    function automatic void drop_from_chain(int e);
        int b, p, n;
        b = bkt(tag_addr[e]);
        p = chn_prev[e];
        n = chn_next[e];
        if (p != Nil) chn_next[p] = n; else bkt_first[b] = n;
        if (n != Nil) chn_prev[n] = p; else bkt_last[b] = p;
        chn_prev[e] = Nil;
        chn_next[e] = Nil;
    endfunction

    function automatic void add_to_chain(int e);
        int b, t;
        b = bkt(tag_addr[e]);
        t = bkt_last[b];
        chn_prev[e] = t;
        chn_next[e] = Nil;
        if (t != Nil) chn_next[t] = e; else bkt_first[b] = e;
        bkt_last[b] = e;
    endfunction

    function automatic t_tag_result predict_tag_access(logic op, logic [31:0] a);
        t_tag_result r;
        int e, guard;
        r = '0;
        if (op == OpLookup) begin
            e = bkt_first[bkt(a)];
            guard = 0;
            while (e != Nil && guard < EntryCount) begin
                if (tag_valid[e] && tag_addr[e] == a) begin
                    make_recent(e);
                    r.hit = 1'b1;
                    r.idx = 6'(e);
                    break;
                end
                e = chn_next[e];
                guard++;
            end
        end else begin
            e = lru_tail;
            make_recent(e);
            if (tag_valid[e]) begin
                r.ev_valid = 1'b1;
                r.ev_addr  = tag_addr[e];
                drop_from_chain(e);
            end
            tag_addr[e]  = a;
            tag_valid[e] = 1'b1;
            add_to_chain(e);
            r.idx = 6'(e);
        end
        return r;
    endfunction

    // Reset the shadow state, then predict on each accepted request and check each result
    always @(posedge i_clk) begin
        t_tag_result got, exp_r;
        if (!i_rst_n) begin
            for (int i = 0; i < EntryCount; i++) begin
                tag_addr[i]  = '0;
                tag_valid[i] = 1'b0;
                lru_prev[i]  = (i == 0) ? Nil : i - 1;
                lru_next[i]  = (i == EntryCount - 1) ? Nil : i + 1;
                chn_prev[i]  = Nil;
                chn_next[i]  = Nil;
            end
            for (int i = 0; i < BucketCount; i++) begin
                bkt_first[i] = Nil;
                bkt_last[i]  = Nil;
            end
            lru_head = 0;
            lru_tail = EntryCount - 1;
            expected_results.delete();
            o_fail_count  <= 0;
            o_hit_count   <= 0;
            o_evict_count <= 0;
            o_pending     <= 0;
        end else begin
            if (i_done) begin
                got = {i_hit, i_entry_index, i_evicted_valid, i_evicted_address};
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected: got %h", $realtime, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        $display("%0t: mismatch hit/idx/ev/evaddr exp %b/%0d/%b/%h got %b/%0d/%b/%h",
                                 $realtime, exp_r.hit, exp_r.idx, exp_r.ev_valid, exp_r.ev_addr,
                                 i_hit, i_entry_index, i_evicted_valid, i_evicted_address);
                        o_fail_count <= o_fail_count + 1;
                    end
                    if (exp_r.hit) o_hit_count <= o_hit_count + 1;
                    if (exp_r.ev_valid) o_evict_count <= o_evict_count + 1;
                end
            end
            if (i_start && !i_busy)
                expected_results.push_back(predict_tag_access(i_operation, i_slice_address));
            o_pending <= expected_results.size();
        end
    end
endmodule

// ----- tb/tb_lru_buffer_tag_store.sv -----
// Testbench top for the LRU buffer tag store: drives lookups and allocates, gives the verdict.
// Depends on lbts_pkg, lru_buffer_tag_store and lbts_checker.
module tb_lru_buffer_tag_store;
    timeunit 1ns;
    timeprecision 1ps;
    import lbts_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_operation = OpLookup;
    logic [31:0] i_slice_address = '0;
    logic        o_done, o_hit, o_evicted_valid;
    logic [5:0]  o_entry_index;
    logic [31:0] o_evicted_address;
    int          fail_count, pending, hit_count, evict_count;
    int          request_count;
    logic [31:0] recent_addrs [$];

    always #4 i_clk = ~i_clk;

    lru_buffer_tag_store DUT (
        .i_clk, .i_rst_n, .start, .busy, .i_operation, .i_slice_address,
        .o_done, .o_hit, .o_entry_index, .o_evicted_valid, .o_evicted_address
    );

    lbts_checker u_checker (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_operation, .i_slice_address,
        .i_done(o_done), .i_hit(o_hit), .i_entry_index(o_entry_index),
        .i_evicted_valid(o_evicted_valid), .i_evicted_address(o_evicted_address),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_hit_count(hit_count), .o_evict_count(evict_count)
    );

    // Present one request and hold it until the block takes it; the caller drops start
    task automatic send_request(logic op, logic [31:0] a);
        i_operation     <= op;
        i_slice_address <= a;
        start           <= 1'b1;
        do @(posedge i_clk); while (busy);
        request_count++;
        if (op == OpAllocate) begin
            recent_addrs.push_back(a);
            if (recent_addrs.size() > 96) void'(recent_addrs.pop_front());
        end
    endtask

    function automatic logic [31:0] pick_address();
        int k;
        k = $urandom_range(0, 9);
        if (k < 5 && recent_addrs.size() > 0)
            return recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
        if (k < 7)
            return {2'($urandom_range(0, 3)), 22'h0, 2'b0, 6'($urandom_range(0, 3))};
        if (k == 7)
            return 32'hFFFF_FFFF - $urandom_range(0, 2);
        return $urandom();
    endfunction

    initial begin
        int gap, burst;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: misses on empty store, extremes, duplicates, chain collisions
        send_request(OpLookup, 32'h0);
        send_request(OpAllocate, 32'h0);
        send_request(OpAllocate, 32'hFFFF_FFFF);
        send_request(OpLookup, 32'hFFFF_FFFF);
        send_request(OpLookup, 32'h0);
        send_request(OpAllocate, 32'h40);
        send_request(OpAllocate, 32'h80);
        send_request(OpAllocate, 32'h40);
        send_request(OpLookup, 32'h80);
        send_request(OpLookup, 32'h40);
        send_request(OpLookup, 32'hC0);
        send_request(OpAllocate, 32'hAAAA_AAAA);
        send_request(OpAllocate, 32'h5555_5555);
        send_request(OpLookup, 32'h5555_5555);
        send_request(OpLookup, 32'hAAAA_AAAA);
        send_request(OpLookup, 32'hFFFF_FFFE);
        start <= 1'b0;

        // Hold off until every outstanding result has returned
        @(posedge i_clk);
        wait (pending == 0);
        repeat (20) @(posedge i_clk);

        // Random bursts with gaps; enough allocates to wrap the LRU and evict
        while (request_count < 1266) begin
            burst = $urandom_range(1, 20);
            for (int i = 0; i < burst; i++)
                send_request(logic'($urandom_range(0, 99) < 45), pick_address());
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        start <= 1'b0;

        @(posedge i_clk);
        wait (pending == 0);
        repeat (40) @(posedge i_clk);
        $display("Ran %0d requests: %0d lookup hits, %0d evictions of valid entries.",
                 request_count, hit_count, evict_count);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Timed out with %0d results outstanding.", pending);
        $display("*** FAILED ***");
        $finish;
    end
endmodule

// ----- lru_buffer_tag_store.f -----
hw/rtl/lbts_pkg.sv
hw/rtl/lbts_ram.sv
hw/rtl/lru_buffer_tag_store.sv
tb/lbts_checker.sv
tb/tb_lru_buffer_tag_store.sv
